// ===== rtl/core/ecd_pkg.sv =====
// Package for the epoch seconds to calendar date core.
// Holds the sequencer state type, calendar constants and month tables.
// No dependencies.
`default_nettype none

package ecd_pkg;

  localparam int SEC_W   = 33;
  localparam int YEAR_W  = 12;
  localparam int ZSUM_W  = 9;

  localparam logic [YEAR_W-1:0] EPOCH_YEAR    = 12'd1970;
  localparam logic [SEC_W-1:0]  SECS_PER_DAY  = 33'd86400;
  localparam logic [SEC_W-1:0]  YEAR_SECS_365 = 33'd31536000;
  localparam logic [SEC_W-1:0]  YEAR_SECS_366 = 33'd31622400;
  localparam logic [SEC_W-1:0]  WEEK_DAYS     = 33'd7;
  localparam logic [3:0]        LAST_MONTH_IX = 4'd11;

  typedef enum logic [2:0] {
    S_IDLE,
    S_YEAR,
    S_MONTH,
    S_DAY,
    S_ZSUM,
    S_ZMOD,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [SEC_W-1:0] diff;
    logic             ge;
  } alu_res_t;

  function automatic logic [4:0] month_days(input logic leap, input logic [3:0] mi);
    logic [4:0] d;
    unique case (mi)
      4'd1:                      d = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:   d = 5'd30;
      default:                   d = 5'd31;
    endcase
    return d;
  endfunction

  function automatic logic [SEC_W-1:0] month_secs(input logic leap, input logic [3:0] mi);
    logic [SEC_W-1:0] s;
    unique case (month_days(leap, mi))
      5'd28:   s = 33'd2419200;
      5'd29:   s = 33'd2505600;
      5'd30:   s = 33'd2592000;
      default: s = 33'd2678400;
    endcase
    return s;
  endfunction

  // The month term of the congruence, with January and February counted as
  // months 13 and 14 of the previous year.
  function automatic logic [5:0] zeller_month_term(input logic [3:0] mi);
    logic [5:0] z;
    unique case (mi)
      4'd0:    z = 6'd36;
      4'd1:    z = 6'd39;
      4'd2:    z = 6'd10;
      4'd3:    z = 6'd13;
      4'd4:    z = 6'd15;
      4'd5:    z = 6'd18;
      4'd6:    z = 6'd20;
      4'd7:    z = 6'd23;
      4'd8:    z = 6'd26;
      4'd9:    z = 6'd28;
      4'd10:   z = 6'd31;
      default: z = 6'd33;
    endcase
    return z;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ecd_alu.sv =====
// Shared subtract and compare unit of the calendar date core.
// Depends on ecd_pkg for the operand width and result struct.
`default_nettype none

module ecd_alu (
  input  wire logic [ecd_pkg::SEC_W-1:0] a,
  input  wire logic [ecd_pkg::SEC_W-1:0] b,
  output ecd_pkg::alu_res_t              res
);
  import ecd_pkg::*;

  logic [SEC_W:0] wide;

  assign wide     = {1'b0, a} - {1'b0, b};
  assign res.diff = wide[SEC_W-1:0];
  assign res.ge   = ~wide[SEC_W];

endmodule

`default_nettype wire

// ===== rtl/core/epoch_seconds_to_calendar_date_core.sv =====
// Top level of the epoch seconds to calendar date core: request port,
// sequencer and calendar counters. Depends on ecd_pkg and ecd_alu.
//
//  channel   handshake          payload
//  request   start, busy        epoch_seconds
//  result    done (strobe)      year, month, day, first_weekday, month_length, leap_year
//
// A request is taken when start is high and busy is low; busy then stays high
// until the result has been shown. One subtractor does the repeated subtraction:
// whole years since 1970 (up to 272), then whole months, then whole days, then
// sevens from the weekday sum. The result is shown for exactly one cycle with
// done high; the receiver cannot stall it. Reset returns the sequencer to idle.
`default_nettype none

module epoch_seconds_to_calendar_date_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [32:0] epoch_seconds,
  output logic             busy,
  output logic             done,
  output logic [11:0]      year,
  output logic [3:0]       month,
  output logic [4:0]       day,
  output logic [2:0]       first_weekday,
  output logic [4:0]       month_length,
  output logic             leap_year
);
  import ecd_pkg::*;

  state_t            state, state_next;
  logic [SEC_W-1:0]  rem, rem_next;
  logic [YEAR_W-1:0] yr, yr_next;
  logic [1:0]        mod4, mod4_next;
  logic [6:0]        mod100, mod100_next;
  logic [8:0]        mod400, mod400_next;
  logic [4:0]        cent, cent_next;
  logic [3:0]        mi, mi_next;
  logic [4:0]        dayc, dayc_next;
  logic [2:0]        wday, wday_next;

  logic              leap;
  logic [SEC_W-1:0]  alu_b;
  alu_res_t          alu_res;
  logic [6:0]        zk;
  logic [4:0]        zj;
  logic [ZSUM_W-1:0] zsum;
  logic [3:0]        wshift;

  assign leap = (mod4 == 2'd0) && ((mod100 != 7'd0) || (mod400 == 9'd0));

  always_comb begin
    unique case (state)
      S_YEAR:  alu_b = leap ? YEAR_SECS_366 : YEAR_SECS_365;
      S_MONTH: alu_b = month_secs(leap, mi);
      S_DAY:   alu_b = SECS_PER_DAY;
      S_ZMOD:  alu_b = WEEK_DAYS;
      default: alu_b = '0;
    endcase
  end

  ecd_alu u_alu (
    .a   (rem),
    .b   (alu_b),
    .res (alu_res)
  );

  always_comb begin
    if (mi < 4'd2) begin
      zk = (mod100 == 7'd0) ? 7'd99 : mod100 - 7'd1;
      zj = (mod100 == 7'd0) ? cent - 5'd1 : cent;
    end else begin
      zk = mod100;
      zj = cent;
    end
    zsum = ZSUM_W'(1) + ZSUM_W'(zeller_month_term(mi)) + ZSUM_W'(zk)
         + ZSUM_W'(zk >> 2) + ZSUM_W'(zj >> 2) + ZSUM_W'({zj, 2'b00}) + ZSUM_W'(zj);
  end

  assign wshift = {1'b0, rem[2:0]} + 4'd5;

  always_comb begin
    state_next  = state;
    rem_next    = rem;
    yr_next     = yr;
    mod4_next   = mod4;
    mod100_next = mod100;
    mod400_next = mod400;
    cent_next   = cent;
    mi_next     = mi;
    dayc_next   = dayc;
    wday_next   = wday;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          rem_next    = epoch_seconds;
          yr_next     = EPOCH_YEAR;
          mod4_next   = 2'd2;
          mod100_next = 7'd70;
          mod400_next = 9'd370;
          cent_next   = 5'd19;
          mi_next     = 4'd0;
          dayc_next   = 5'd1;
          state_next  = S_YEAR;
        end
      end
      S_YEAR: begin
        if (alu_res.ge) begin
          rem_next    = alu_res.diff;
          yr_next     = yr + 12'd1;
          mod4_next   = mod4 + 2'd1;
          mod100_next = (mod100 == 7'd99) ? 7'd0 : mod100 + 7'd1;
          mod400_next = (mod400 == 9'd399) ? 9'd0 : mod400 + 9'd1;
          cent_next   = (mod100 == 7'd99) ? cent + 5'd1 : cent;
        end else begin
          state_next = S_MONTH;
        end
      end
      S_MONTH: begin
        if ((mi < LAST_MONTH_IX) && alu_res.ge) begin
          rem_next = alu_res.diff;
          mi_next  = mi + 4'd1;
        end else begin
          state_next = S_DAY;
        end
      end
      S_DAY: begin
        if (alu_res.ge) begin
          rem_next  = alu_res.diff;
          dayc_next = dayc + 5'd1;
        end else begin
          state_next = S_ZSUM;
        end
      end
      S_ZSUM: begin
        rem_next   = SEC_W'(zsum);
        state_next = S_ZMOD;
      end
      S_ZMOD: begin
        if (alu_res.ge) begin
          rem_next = alu_res.diff;
        end else begin
          wday_next  = (wshift >= 4'd7) ? 3'(wshift - 4'd7) : wshift[2:0];
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    rem    <= rem_next;
    yr     <= yr_next;
    mod4   <= mod4_next;
    mod100 <= mod100_next;
    mod400 <= mod400_next;
    cent   <= cent_next;
    mi     <= mi_next;
    dayc   <= dayc_next;
    wday   <= wday_next;
  end

  assign busy          = (state != S_IDLE);
  assign done          = (state == S_DONE);
  assign year          = yr;
  assign month         = mi + 4'd1;
  assign day           = dayc;
  assign first_weekday = wday;
  assign month_length  = month_days(leap, mi);
  assign leap_year     = leap;

endmodule

`default_nettype wire

// ===== bench/tb_epoch_seconds_to_calendar_date_core.sv =====
// Testbench for epoch_seconds_to_calendar_date_core: directed and random timestamps
// are converted by an independent calendar predictor and checked result by result.
// Depends on ecd_pkg and the core RTL.

module tb_epoch_seconds_to_calendar_date_core;
  timeunit 1ns;
  timeprecision 1ps;

  import ecd_pkg::*;

  localparam int  FEBRUARY      = 2;
  localparam int  LAST_YEAR     = 2242;
  localparam int  THURSDAY      = 3;
  localparam int  RANDOM_COUNT  = 930;
  localparam int  CALM_FIRST    = 300;
  localparam int  CALM_LAST     = 450;
  localparam int  DRAIN_AT      = 600;
  localparam int  SETTLE_CYCLES = 400;
  localparam int  CYCLE_LIMIT   = 2000000;
  localparam longint unsigned MAX_SECS = 64'h1_FFFF_FFFF;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [2:0]  first_weekday;
    logic [4:0]  month_length;
    logic        leap_year;
  } calendar_t;

  function automatic bit is_leap(int unsigned y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic int unsigned month_day_count(int unsigned y, int unsigned m);
    case (m)
      FEBRUARY:      return is_leap(y) ? 29 : 28;
      4, 6, 9, 11:   return 30;
      default:       return 31;
    endcase
  endfunction

  function automatic longint unsigned date_to_secs(int unsigned y, int unsigned m,
                                                   int unsigned d, int unsigned sod);
    longint unsigned days;
    days = 0;
    for (int unsigned yy = EPOCH_YEAR; yy < y; yy++) days += is_leap(yy) ? 366 : 365;
    for (int unsigned mm = 1; mm < m; mm++) days += month_day_count(y, mm);
    return (days + d - 1) * 86400 + sod;
  endfunction

  class date_scoreboard;
    calendar_t   pending_dates[$];
    int unsigned requests, checked, mismatches, leap_results;
    int unsigned min_year = 4095;
    int unsigned max_year = 0;

    function calendar_t to_calendar(logic [32:0] secs);
      logic [32:0] rest;
      int unsigned yr, mi, days;
      calendar_t   c;
      rest = secs;
      yr   = EPOCH_YEAR;
      days = 0;
      while (rest >= (is_leap(yr) ? 33'd366 : 33'd365) * SECS_PER_DAY) begin
        rest -= (is_leap(yr) ? 33'd366 : 33'd365) * SECS_PER_DAY;
        days += is_leap(yr) ? 366 : 365;
        yr++;
      end
      mi = 1;
      while (mi < 12 && rest >= 33'(month_day_count(yr, mi)) * SECS_PER_DAY) begin
        rest -= 33'(month_day_count(yr, mi)) * SECS_PER_DAY;
        days += month_day_count(yr, mi);
        mi++;
      end
      c.year          = 12'(yr);
      c.month         = 4'(mi);
      c.day           = 5'(rest / SECS_PER_DAY + 1);
      c.first_weekday = 3'((days + THURSDAY) % 7);
      c.month_length  = 5'(month_day_count(yr, mi));
      c.leap_year     = is_leap(yr);
      return c;
    endfunction

    function void note_request(logic [32:0] secs);
      pending_dates.push_back(to_calendar(secs));
      requests++;
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s mismatch: expected %0d, actual %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(calendar_t got);
      calendar_t want;
      if (pending_dates.size() == 0) begin
        $error("result with no request waiting: year %0d month %0d day %0d",
               got.year, got.month, got.day);
        mismatches++;
        return;
      end
      want = pending_dates.pop_front();
      compare_field("year", want.year, got.year);
      compare_field("month", want.month, got.month);
      compare_field("day", want.day, got.day);
      compare_field("first_weekday", want.first_weekday, got.first_weekday);
      compare_field("month_length", want.month_length, got.month_length);
      compare_field("leap_year", want.leap_year, got.leap_year);
      checked++;
      if (want.leap_year) leap_results++;
      if (want.year < min_year) min_year = want.year;
      if (want.year > max_year) max_year = want.year;
    endfunction

    function int unsigned outstanding();
      return pending_dates.size();
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        start;
  logic [32:0] epoch_seconds;
  logic        busy;
  logic        done;
  logic [11:0] year;
  logic [3:0]  month;
  logic [4:0]  day;
  logic [2:0]  first_weekday;
  logic [4:0]  month_length;
  logic        leap_year;

  date_scoreboard sb = new();
  int unsigned    cycles = 0;

  epoch_seconds_to_calendar_date_core u_top (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .epoch_seconds (epoch_seconds),
    .busy          (busy),
    .done          (done),
    .year          (year),
    .month         (month),
    .day           (day),
    .first_weekday (first_weekday),
    .month_length  (month_length),
    .leap_year     (leap_year)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      sb.check_result({year, month, day, first_weekday, month_length, leap_year});
    end
  end

  task automatic send_request(input logic [32:0] secs);
    start         <= 1'b1;
    epoch_seconds <= secs;
    do @(posedge clk); while (busy);
    sb.note_request(secs);
  endtask

  task automatic maybe_idle();
    if ($urandom_range(99) < 38) begin
      start <= 1'b0;
      repeat ($urandom_range(12, 1)) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.outstanding() > 0) @(posedge clk);
  endtask

  function automatic logic [32:0] random_stamp();
    int unsigned     pick, y, m, d, sod;
    longint unsigned secs;
    pick = $urandom_range(99);
    if (pick < 60) begin
      y   = $urandom_range(LAST_YEAR, EPOCH_YEAR);
      m   = $urandom_range(12, 1);
      d   = ($urandom_range(3) == 0) ? month_day_count(y, m)
                                     : $urandom_range(month_day_count(y, m), 1);
      sod = ($urandom_range(3) == 0) ? ($urandom_range(1) ? 86399 : 0)
                                     : $urandom_range(86399);
      secs = date_to_secs(y, m, d, sod);
      if (secs <= MAX_SECS) return 33'(secs);
    end else if (pick < 70) begin
      return 33'($urandom_range(100000000));
    end
    return {1'($urandom_range(1)), 32'($urandom)};
  endfunction

  initial begin
    start         <= 1'b0;
    epoch_seconds <= '0;
    rst           <= 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    send_request('0);
    send_request(33'(MAX_SECS));
    send_request(33'(date_to_secs(1970, 12, 31, 86399)));
    send_request(33'(date_to_secs(1971, 1, 1, 0)));
    send_request(33'(date_to_secs(1972, 2, 29, 43200)));
    send_request(33'(date_to_secs(1972, 3, 1, 0)));
    send_request(33'(date_to_secs(2000, 2, 29, 0)));
    send_request(33'(date_to_secs(2000, 12, 31, 86399)));
    send_request(33'(date_to_secs(2100, 2, 28, 86399)));
    send_request(33'(date_to_secs(2100, 3, 1, 0)));
    send_request(33'(date_to_secs(2200, 2, 28, 12345)));
    send_request(33'(date_to_secs(2024, 2, 29, 1)));
    for (int m = 1; m <= 12; m++) begin
      send_request(33'(date_to_secs(2001, m, (m % 2 == 0) ? month_day_count(2001, m) : 1,
                                    (m % 2 == 0) ? 86399 : 0)));
    end

    for (int i = 0; i < RANDOM_COUNT; i++) begin
      if (i == DRAIN_AT) drain();
      if (i < CALM_FIRST || i >= CALM_LAST) maybe_idle();
      send_request(random_stamp());
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Converted %0d of %0d timestamps, years %0d to %0d, %0d in leap years.",
             sb.checked, sb.requests, sb.min_year, sb.max_year, sb.leap_results);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/ecd_pkg.sv
rtl/core/ecd_alu.sv
rtl/core/epoch_seconds_to_calendar_date_core.sv
bench/tb_epoch_seconds_to_calendar_date_core.sv
